>>> rtl/core/mtet_pkg.sv
// Shared types and constants of the multi-turn encoder tracker.
`default_nettype none

package mtet_pkg;

  localparam int ANGLE_W   = 13;
  localparam int SPEED_W   = 16;
  localparam int CURRENT_W = 16;
  localparam int TEMP_W    = 8;
  localparam int Q10_W     = 19;
  localparam int TURN_W    = 19;
  localparam int POS_W     = 32;
  localparam int FILT_W    = 10;
  localparam int THR_W     = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [0:0] REG_ZERO_ANGLE = 1'b0;
  localparam logic [0:0] REG_JUMP_THR   = 1'b1;

  localparam logic [ANGLE_W-1:0] ZERO_ANGLE_RST = 13'd0;
  localparam logic [THR_W-1:0]   JUMP_THR_RST   = 10'd500;

  localparam logic signed [14:0] ANGLE_HALF = 15'sd4096;
  localparam logic signed [14:0] ANGLE_TURN = 15'sd8192;
  localparam logic signed [Q10_W-1:0] ANGLE_Q10_SCALE = 19'sd45;

  // floor(x / 100) == (x * 5243) >> 19 for x <= 32768
  localparam logic [12:0] DIV100_MULT = 13'd5243;
  // floor(x / 5) == (x * 3277) >> 14 for x < 4096
  localparam logic [11:0] DIV5_MULT   = 12'd3277;

  localparam logic signed [FILT_W-1:0] SPEED_MAX = 10'sd327;

  typedef struct packed {
    logic [ANGLE_W-1:0] zero_angle;
    logic [THR_W-1:0]   jump_threshold;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/mtet_in_if.sv
// Feedback frame channel: valid/ready handshake with the frame fields.
`default_nettype none

interface mtet_in_if;
  logic                                       valid;
  logic                                       ready;
  logic        [mtet_pkg::ANGLE_W-1:0]        angle_raw;
  logic signed [mtet_pkg::SPEED_W-1:0]        speed_raw;
  logic signed [mtet_pkg::CURRENT_W-1:0]      current_raw;
  logic        [mtet_pkg::TEMP_W-1:0]         coil_temp;
  logic        [mtet_pkg::TEMP_W-1:0]         mos_temp;

  modport source (
    output valid, angle_raw, speed_raw, current_raw, coil_temp, mos_temp,
    input  ready
  );

  modport sink (
    input  valid, angle_raw, speed_raw, current_raw, coil_temp, mos_temp,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/mtet_out_if.sv
// Result channel: valid/ready handshake with the tracked position fields.
`default_nettype none

interface mtet_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mtet_pkg::Q10_W-1:0]     relative_angle_q10;
  logic signed [mtet_pkg::TURN_W-1:0]    turn_count;
  logic signed [mtet_pkg::POS_W-1:0]     multi_turn_position;
  logic signed [mtet_pkg::FILT_W-1:0]    speed_filtered;
  logic signed [mtet_pkg::CURRENT_W-1:0] current_out;
  logic        [mtet_pkg::TEMP_W-1:0]    coil_temp_out;
  logic        [mtet_pkg::TEMP_W-1:0]    mos_temp_out;

  modport source (
    output valid, relative_angle_q10, turn_count, multi_turn_position, speed_filtered,
           current_out, coil_temp_out, mos_temp_out,
    input  ready
  );

  modport sink (
    input  valid, relative_angle_q10, turn_count, multi_turn_position, speed_filtered,
           current_out, coil_temp_out, mos_temp_out,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/mtet_cfg_regs.sv
// APB configuration registers: zero angle and speed jump threshold.
`default_nettype none

module mtet_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [mtet_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [mtet_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [mtet_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready,
  output mtet_pkg::cfg_t                           cfg
);

  mtet_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [0:0]     reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_angle     <= mtet_pkg::ZERO_ANGLE_RST;
      cfg_r.jump_threshold <= mtet_pkg::JUMP_THR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mtet_pkg::REG_ZERO_ANGLE: cfg_r.zero_angle <= cfg_pwdata[mtet_pkg::ANGLE_W-1:0];
        mtet_pkg::REG_JUMP_THR:   cfg_r.jump_threshold <= cfg_pwdata[mtet_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mtet_pkg::REG_ZERO_ANGLE:
        cfg_prdata = {{(mtet_pkg::CFG_DATA_W - mtet_pkg::ANGLE_W){1'b0}}, cfg_r.zero_angle};
      mtet_pkg::REG_JUMP_THR:
        cfg_prdata = {{(mtet_pkg::CFG_DATA_W - mtet_pkg::THR_W){1'b0}}, cfg_r.jump_threshold};
      default:
        cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/mtet_core.sv
// Tracking datapath: input stage, turn counting, speed filter and result stage.
`default_nettype none

module mtet_core (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire mtet_pkg::cfg_t cfg,
  mtet_in_if.sink      in_bus,
  mtet_out_if.source   out_bus
);

  // input stage
  logic                                    s1_valid_r;
  logic                                    s1_valid_nxt;
  logic        [mtet_pkg::ANGLE_W-1:0]     s1_angle_r;
  logic signed [mtet_pkg::FILT_W-1:0]      s1_now_r;
  logic signed [mtet_pkg::CURRENT_W-1:0]   s1_current_r;
  logic        [mtet_pkg::TEMP_W-1:0]      s1_coil_r;
  logic        [mtet_pkg::TEMP_W-1:0]      s1_mos_r;

  // tracking state
  logic        [mtet_pkg::ANGLE_W-1:0]     prev_angle_r;
  logic        [mtet_pkg::TURN_W-1:0]      turn_r;
  logic        [mtet_pkg::TURN_W-1:0]      turn_nxt;
  logic signed [mtet_pkg::FILT_W-1:0]      filt_r;
  logic signed [mtet_pkg::FILT_W-1:0]      filt_nxt;

  // result stage
  logic                                    out_valid_r;
  logic                                    out_valid_nxt;
  logic signed [mtet_pkg::Q10_W-1:0]       out_angle_r;
  logic        [mtet_pkg::TURN_W-1:0]      out_turn_r;
  logic        [mtet_pkg::POS_W-1:0]       out_pos_r;
  logic signed [mtet_pkg::FILT_W-1:0]      out_speed_r;
  logic signed [mtet_pkg::CURRENT_W-1:0]   out_current_r;
  logic        [mtet_pkg::TEMP_W-1:0]      out_coil_r;
  logic        [mtet_pkg::TEMP_W-1:0]      out_mos_r;

  logic in_acc;
  logic s1_adv;

  // speed / 100
  logic        [16:0] spd_mag;
  logic        [29:0] spd_prod;
  logic        [8:0]  spd_quo;
  logic signed [mtet_pkg::FILT_W-1:0] spd_now;

  // filter
  logic signed [10:0] flt_diff;
  logic        [10:0] flt_adiff;
  logic               flt_old;
  logic signed [12:0] flt_sum;
  logic        [12:0] flt_neg;
  logic        [11:0] flt_mag;
  logic        [23:0] flt_prod;
  logic        [9:0]  flt_quo;

  // angle
  logic signed [14:0] ang_err;
  logic signed [14:0] ang_wrap;
  logic signed [14:0] ang_jump;
  logic signed [mtet_pkg::Q10_W-1:0] ang_q10;

  assign in_acc       = in_bus.valid && in_bus.ready;
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);

  always_comb begin
    spd_mag  = in_bus.speed_raw[15] ? (17'd0 - {1'b1, in_bus.speed_raw})
                                    : {1'b0, in_bus.speed_raw};
    spd_prod = spd_mag * mtet_pkg::DIV100_MULT;
    spd_quo  = spd_prod[27:19];
    spd_now  = in_bus.speed_raw[15] ? -$signed({1'b0, spd_quo}) : $signed({1'b0, spd_quo});
  end

  always_comb begin
    flt_diff  = 11'(s1_now_r) - 11'(filt_r);
    flt_adiff = flt_diff[10] ? (11'd0 - flt_diff) : flt_diff;
    flt_old   = flt_adiff >= {1'b0, cfg.jump_threshold};
    flt_sum   = flt_old ? (13'(s1_now_r) + (13'(filt_r) <<< 2))
                        : ((13'(s1_now_r) <<< 2) + 13'(filt_r));
    flt_neg   = 13'd0 - flt_sum;
    flt_mag   = flt_sum[12] ? flt_neg[11:0] : flt_sum[11:0];
    flt_prod  = flt_mag * mtet_pkg::DIV5_MULT;
    flt_quo   = flt_prod[23:14];
    filt_nxt  = flt_sum[12] ? $signed(10'd0 - flt_quo) : $signed(flt_quo);
  end

  always_comb begin
    ang_err = $signed({2'b00, s1_angle_r}) - $signed({2'b00, cfg.zero_angle});
    if (ang_err > mtet_pkg::ANGLE_HALF) begin
      ang_wrap = ang_err - mtet_pkg::ANGLE_TURN;
    end else if (ang_err < -mtet_pkg::ANGLE_HALF) begin
      ang_wrap = ang_err + mtet_pkg::ANGLE_TURN;
    end else begin
      ang_wrap = ang_err;
    end
    ang_q10 = 19'(ang_wrap) * mtet_pkg::ANGLE_Q10_SCALE;

    ang_jump = $signed({2'b00, s1_angle_r}) - $signed({2'b00, prev_angle_r});
    if (ang_jump < -mtet_pkg::ANGLE_HALF) begin
      turn_nxt = turn_r + 19'd1;
    end else if (ang_jump > mtet_pkg::ANGLE_HALF) begin
      turn_nxt = turn_r - 19'd1;
    end else begin
      turn_nxt = turn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_angle_r <= '0;
      turn_r       <= '0;
      filt_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        prev_angle_r <= s1_angle_r;
        turn_r       <= turn_nxt;
        filt_r       <= filt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_angle_r   <= in_bus.angle_raw;
      s1_now_r     <= spd_now;
      s1_current_r <= in_bus.current_raw;
      s1_coil_r    <= in_bus.coil_temp;
      s1_mos_r     <= in_bus.mos_temp;
    end
    if (s1_adv) begin
      out_angle_r   <= ang_q10;
      out_turn_r    <= turn_nxt;
      out_pos_r     <= {turn_nxt, s1_angle_r};
      out_speed_r   <= filt_nxt;
      out_current_r <= s1_current_r;
      out_coil_r    <= s1_coil_r;
      out_mos_r     <= s1_mos_r;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.relative_angle_q10  = out_angle_r;
  assign out_bus.turn_count          = $signed(out_turn_r);
  assign out_bus.multi_turn_position = $signed(out_pos_r);
  assign out_bus.speed_filtered      = out_speed_r;
  assign out_bus.current_out         = out_current_r;
  assign out_bus.coil_temp_out       = out_coil_r;
  assign out_bus.mos_temp_out        = out_mos_r;

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(turn_r) && $stable(filt_r) && $stable(prev_angle_r))
    else $error("tracking state changed without an advancing item");

  a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (turn_r == $past(turn_r)) || (turn_r == $past(turn_r) + 19'd1) ||
               (turn_r == $past(turn_r) - 19'd1))
    else $error("turn counter moved by more than one turn");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pos_r[12:0] == prev_angle_r) && (out_turn_r == turn_r) &&
                    (out_speed_r == filt_r))
    else $error("result beat disagrees with tracking state");

  a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (filt_r >= -mtet_pkg::SPEED_MAX) && (filt_r <= mtet_pkg::SPEED_MAX))
    else $error("filtered speed out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/multi_turn_encoder_tracker_top.sv
// Multi-turn encoder tracker top level.
//
// in_bus carries one motor feedback frame per beat (angle, speed, current,
// two temperatures); out_bus returns one result beat per frame with the
// wrapped relative angle in Q10 degrees, the turn count, the multi-turn
// position, the filtered speed and the passed-through current and temps.
// cfg_* is an APB-style port: zero_angle at byte address 0, jump_threshold
// at byte address 4; pready is always high, reads return the register.
//
// A frame accepted on in_bus is registered in the input stage and moves to
// the result register when that is free, from which out_bus presents it.
// Throughput: one frame per cycle while out_bus does not stall; the turn
// counter and speed filter state update in the same cycle as the result
// register, so back-to-back frames see each other's state.
// When the receiver stalls, the result beat holds and one more frame can be
// taken into the input stage; in_bus.ready then drops until out_bus moves.
// Synchronous reset clears both stages, the angle history, the turn counter
// and the filter, and loads the register reset values (zero angle 0,
// jump threshold 500).
`default_nettype none

module multi_turn_encoder_tracker_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  mtet_in_if.sink                               in_bus,
  mtet_out_if.source                            out_bus,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [mtet_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [mtet_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [mtet_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready
);

  mtet_pkg::cfg_t cfg;

  mtet_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  mtet_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

>>> tb/tb_multi_turn_encoder_tracker_top.sv
// Self-checking testbench for the multi-turn encoder tracker top level.
`timescale 1ns / 100ps

module tb_multi_turn_encoder_tracker_top;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int WRAP_TURNS   = 20;
  localparam int PHASE_FRAMES = 78;

  typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

  typedef struct packed {
    logic        [mtet_pkg::ANGLE_W-1:0]   angle;
    logic signed [mtet_pkg::SPEED_W-1:0]   speed;
    logic signed [mtet_pkg::CURRENT_W-1:0] current;
    logic        [mtet_pkg::TEMP_W-1:0]    coil;
    logic        [mtet_pkg::TEMP_W-1:0]    mos;
  } frame_t;

  typedef struct packed {
    logic signed [mtet_pkg::Q10_W-1:0]     angle_q10;
    logic signed [mtet_pkg::TURN_W-1:0]    turns;
    logic signed [mtet_pkg::POS_W-1:0]     position;
    logic signed [mtet_pkg::FILT_W-1:0]    speed;
    logic signed [mtet_pkg::CURRENT_W-1:0] current;
    logic        [mtet_pkg::TEMP_W-1:0]    coil;
    logic        [mtet_pkg::TEMP_W-1:0]    mos;
  } track_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [mtet_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [mtet_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [mtet_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  mtet_in_if  in_bus ();
  mtet_out_if out_bus ();

  multi_turn_encoder_tracker_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic        [mtet_pkg::ANGLE_W-1:0] zero_angle_q = mtet_pkg::ZERO_ANGLE_RST;
  logic        [mtet_pkg::THR_W-1:0]   jump_thr_q   = mtet_pkg::JUMP_THR_RST;
  logic        [mtet_pkg::ANGLE_W-1:0] last_angle   = '0;
  logic signed [mtet_pkg::TURN_W-1:0]  turn_total   = '0;
  logic signed [mtet_pkg::FILT_W-1:0]  speed_smooth = '0;

  track_t      tracked_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          hold_cycles = 0;
  bit          no_gaps = 1'b0;
  rx_mode_t    rx_mode = RX_PATTERN;
  logic [15:0] stall_pattern = 16'hB5E7;

  always #1 clk = ~clk;

  function automatic track_t track_frame(frame_t f);
    track_t r;
    int     offset;
    int     jump;
    int     now;
    int     last;
    int     delta;
    int     smooth;
    offset = int'(f.angle) - int'(zero_angle_q);
    if (offset > int'(mtet_pkg::ANGLE_HALF)) offset -= int'(mtet_pkg::ANGLE_TURN);
    else if (offset < -int'(mtet_pkg::ANGLE_HALF)) offset += int'(mtet_pkg::ANGLE_TURN);
    jump = int'(f.angle) - int'(last_angle);
    if (jump < -int'(mtet_pkg::ANGLE_HALF)) turn_total = turn_total + 19'sd1;
    else if (jump > int'(mtet_pkg::ANGLE_HALF)) turn_total = turn_total - 19'sd1;
    last_angle = f.angle;
    now = int'(f.speed) / 100;
    last = int'(speed_smooth);
    delta = now - last;
    if (delta < 0) delta = -delta;
    if (delta >= int'(jump_thr_q)) smooth = (now + 4 * last) / 5;
    else smooth = (4 * now + last) / 5;
    speed_smooth = mtet_pkg::FILT_W'(smooth);
    r.angle_q10 = mtet_pkg::Q10_W'(offset * int'(mtet_pkg::ANGLE_Q10_SCALE));
    r.turns     = turn_total;
    r.position  = {turn_total, {mtet_pkg::ANGLE_W{1'b0}}} + mtet_pkg::POS_W'(f.angle);
    r.speed     = speed_smooth;
    r.current   = f.current;
    r.coil      = f.coil;
    r.mos       = f.mos;
    return r;
  endfunction

  function automatic frame_t make_frame(int angle, int speed, int current, int coil, int mos);
    frame_t f;
    f.angle   = mtet_pkg::ANGLE_W'(angle);
    f.speed   = mtet_pkg::SPEED_W'(speed);
    f.current = mtet_pkg::CURRENT_W'(current);
    f.coil    = mtet_pkg::TEMP_W'(coil);
    f.mos     = mtet_pkg::TEMP_W'(mos);
    return f;
  endfunction

  function automatic frame_t random_frame();
    return make_frame($urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL multi_turn_encoder_tracker_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    track_t want;
    track_t got;
    if (rst_n && in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
      tracked_q.push_back(track_frame(frame_t'{in_bus.angle_raw, in_bus.speed_raw,
                                               in_bus.current_raw, in_bus.coil_temp,
                                               in_bus.mos_temp}));
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got = track_t'{out_bus.relative_angle_q10, out_bus.turn_count,
                     out_bus.multi_turn_position, out_bus.speed_filtered,
                     out_bus.current_out, out_bus.coil_temp_out, out_bus.mos_temp_out};
      if (tracked_q.size() == 0) begin
        $error("result beat with no frame pending");
        errors++;
      end else begin
        want = tracked_q.pop_front();
        check_field("relative_angle_q10", 64'(want.angle_q10), 64'(got.angle_q10));
        check_field("turn_count", 64'(want.turns), 64'(got.turns));
        check_field("multi_turn_position", 64'(want.position), 64'(got.position));
        check_field("speed_filtered", 64'(want.speed), 64'(got.speed));
        check_field("current_out", 64'(want.current), 64'(got.current));
        check_field("coil_temp_out", 64'(want.coil), 64'(got.coil));
        check_field("mos_temp_out", 64'(want.mos), 64'(got.mos));
      end
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (rx_mode == RX_ALWAYS) begin
        out_bus.ready <= 1'b1;
      end else if (rx_mode == RX_PATTERN) begin
        out_bus.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        if ($urandom_range(0, 63) == 0) stall_pattern = 16'($urandom) | 16'h0001;
      end else begin
        out_bus.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_frame(frame_t f);
    if (burst_left == 0) begin
      if (!no_gaps) begin
        repeat ($urandom_range(0, 6)) begin
          @(negedge clk);
          in_bus.valid <= 1'b0;
        end
      end
      burst_left = no_gaps ? 1 << 30 : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.angle_raw   <= f.angle;
    in_bus.speed_raw   <= f.speed;
    in_bus.current_raw <= f.current;
    in_bus.coil_temp   <= f.coil;
    in_bus.mos_temp    <= f.mos;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (tracked_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [mtet_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (idx == mtet_pkg::REG_ZERO_ANGLE) zero_angle_q = data[mtet_pkg::ANGLE_W-1:0];
    else jump_thr_q = data[mtet_pkg::THR_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_config(int zero, int thr);
    logic [mtet_pkg::CFG_DATA_W-1:0] data;
    drain_results();
    data = $urandom;
    data[mtet_pkg::ANGLE_W-1:0] = mtet_pkg::ANGLE_W'(zero);
    write_reg(mtet_pkg::REG_ZERO_ANGLE, data);
    data = $urandom;
    data[mtet_pkg::THR_W-1:0] = mtet_pkg::THR_W'(thr);
    write_reg(mtet_pkg::REG_JUMP_THR, data);
  endtask

  task automatic test_directed_frames();
    rx_mode = RX_PATTERN;
    send_frame(make_frame(5000, 32767, -32768, 0, 255));
    send_frame(make_frame(904, -32768, 32767, 255, 0));
    send_frame(make_frame(5000, -32768, 0, 8'hAA, 8'h55));
    send_frame(make_frame(4096, 99, -1, 8'h55, 8'hAA));
    send_frame(make_frame(8191, -99, 1, 1, 128));
    send_frame(make_frame(0, -101, 12345, 128, 1));
    send_frame(make_frame(8191, 32767, -12345, 7, 254));
    send_frame(make_frame(0, 0, 0, 0, 0));
    send_frame(make_frame(3000, 650, 100, 60, 70));
    send_frame(make_frame(6000, -650, -100, 61, 71));
  endtask

  task automatic test_register_extremes();
    rx_mode = RX_RANDOM;
    set_config(4096, 0);
    send_frame(make_frame(0, 32767, 1, 20, 30));
    send_frame(make_frame(8191, -32768, 2, 21, 31));
    send_frame(make_frame(4096, 500, 3, 22, 32));
    send_frame(make_frame(4095, -500, 4, 23, 33));
    set_config(8191, 1023);
    send_frame(make_frame(0, 32767, 5, 24, 34));
    send_frame(make_frame(8191, -32768, 6, 25, 35));
    send_frame(make_frame(4095, 32767, 7, 26, 36));
    send_frame(make_frame(4094, 0, 8, 27, 37));
    set_config(int'(mtet_pkg::ZERO_ANGLE_RST), int'(mtet_pkg::JUMP_THR_RST));
  endtask

  task automatic test_backpressure();
    drain_results();
    rx_mode = RX_ALWAYS;
    no_gaps = 1'b1;
    hold_cycles = 120;
    repeat (30) send_frame(random_frame());
    drain_results();
    no_gaps = 1'b0;
  endtask

  task automatic test_turn_wrap();
    frame_t f;
    rx_mode = RX_ALWAYS;
    no_gaps = 1'b1;
    for (int i = 0; i < WRAP_TURNS; i++) begin
      for (int k = 0; k < 3; k++) begin
        f = random_frame();
        f.angle = mtet_pkg::ANGLE_W'(k * 2731 + $urandom_range(0, 100));
        send_frame(f);
      end
    end
    for (int i = 0; i < 2 * WRAP_TURNS; i++) begin
      for (int k = 0; k < 3; k++) begin
        f = random_frame();
        f.angle = mtet_pkg::ANGLE_W'(((3 - k) % 3) * 2731 + $urandom_range(0, 100));
        send_frame(f);
      end
    end
    drain_results();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    frame_t                       f;
    logic [mtet_pkg::ANGLE_W-1:0] walk_angle;
    int                           speed_base;
    int                           pick;
    walk_angle = '0;
    speed_base = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: set_config(0, 1023);
        1: set_config(8191, 0);
        2: set_config($urandom_range(0, 8191), $urandom_range(0, 1023));
        default: set_config($urandom_range(0, 8191), $urandom_range(0, 40));
      endcase
      rx_mode = rx_mode_t'(phase % 3);
      no_gaps = (phase == 3 || phase == 6);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        f = random_frame();
        pick = $urandom_range(0, 9);
        if (pick < 7)
          walk_angle = walk_angle + mtet_pkg::ANGLE_W'(int'($urandom_range(0, 8400)) - 4200);
        else if (pick < 9)
          walk_angle = walk_angle + mtet_pkg::ANGLE_W'(4095 + $urandom_range(0, 2));
        else walk_angle = mtet_pkg::ANGLE_W'($urandom);
        f.angle = walk_angle;
        if ($urandom_range(0, 9) < 6) begin
          speed_base = speed_base + int'($urandom_range(0, 4000)) - 2000;
          if (speed_base > 32767 || speed_base < -32768) speed_base = 0;
          f.speed = mtet_pkg::SPEED_W'(speed_base);
        end
        send_frame(f);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.angle_raw   = '0;
    in_bus.speed_raw   = '0;
    in_bus.current_raw = '0;
    in_bus.coil_temp   = '0;
    in_bus.mos_temp    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_register_extremes();
    test_backpressure();
    test_turn_wrap();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("PASS multi_turn_encoder_tracker_top");
    else $display("FAIL multi_turn_encoder_tracker_top");
    $finish;
  end

endmodule

>>> files.f
rtl/core/mtet_pkg.sv
rtl/core/mtet_in_if.sv
rtl/core/mtet_out_if.sv
rtl/core/mtet_cfg_regs.sv
rtl/core/mtet_core.sv
rtl/core/multi_turn_encoder_tracker_top.sv
tb/tb_multi_turn_encoder_tracker_top.sv
